[rtl/pbar_pkg.sv]
// Shared types and constants for the per-bit addend recoder.
package pbar_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int IDX_IN_W      = 5;
  localparam int OPND_W        = 32;
  localparam int RES_W         = 32;
  localparam int REQ_W         = 2;
  localparam int IN_DATA_W     = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_FWD   = 2'd1,
    REQ_INV   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

endpackage

[rtl/per_bit_addend_recode.sv]
// Top level of the per-bit addend recoder: sequencer plus output register.
//
// Use: requests enter on the in_ stream. tuser carries the request kind
// (write addend, forward recode, inverse recode); tdata carries the table
// index and the operand. A write stores the operand as the addend of one
// bit position and gives no result. A forward request returns the word
// whose bit i is bit i of (x + addend i); an inverse request recovers x.
// Results leave on the out_ stream, one per recode request, in order.
// Throughput: one write per cycle while no recode is in progress. A recode
// walks the table in the sequencer (one table read and one adder pass per
// bit position, the table read port delivering one entry per cycle), then
// hands the word to the output register; the next request is taken only
// after the hand-off.
// Reset clears the valid bits of the table, so every addend reads as zero
// until written; no clearing pass is needed. When the receiver stalls, the
// result holds in the output register and the block still takes writes and
// one more recode, which then waits in the sequencer until the register frees.
module per_bit_addend_recode #(
  parameter int WORD_BITS = pbar_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [4:0] bit_index, [36:5] operand, [39:37] zero
  input  logic [pbar_pkg::IN_DATA_W-1:0] in_tdata,
  // [1:0] req_type
  input  logic [pbar_pkg::REQ_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] result_word
  output logic [pbar_pkg::RES_W-1:0]     out_tdata
);
  import pbar_pkg::*;

  localparam int IDX_W = $clog2(WORD_BITS);

  logic             res_valid;
  logic             res_ready;
  logic [RES_W-1:0] res_word;
  logic             out_valid_r;
  logic [RES_W-1:0] out_data_r;

  pbar_seq #(
    .WORD_BITS(WORD_BITS),
    .IDX_W    (IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_type   (req_t'(in_tuser)),
    .req_index  (in_tdata[IDX_IN_W-1:0]),
    .req_operand(in_tdata[IDX_IN_W+OPND_W-1:IDX_IN_W]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_word   (res_word)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/pbar_table.sv]
// Addend table: one synchronous memory with a registered read port and per-entry valid bits.
module pbar_table #(
  parameter int WORD_BITS = pbar_pkg::WORD_BITS_DEF,
  parameter int IDX_W     = $clog2(WORD_BITS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);
  import pbar_pkg::*;

  logic [WORD_BITS-1:0] mem [WORD_BITS];
  logic [WORD_BITS-1:0] valid_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[rtl/pbar_seq.sv]
// Bit-serial sequencer: walks the table once per recode request and builds the result word.
module pbar_seq #(
  parameter int WORD_BITS = pbar_pkg::WORD_BITS_DEF,
  parameter int IDX_W     = $clog2(WORD_BITS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  pbar_pkg::req_t         req_type,
  input  logic [pbar_pkg::IDX_IN_W-1:0] req_index,
  input  logic [pbar_pkg::OPND_W-1:0]   req_operand,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [pbar_pkg::RES_W-1:0]    res_word
);
  import pbar_pkg::*;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     cnt_r;
  logic [WORD_BITS-1:0] mask_r;
  logic [WORD_BITS-1:0] op_r;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic                 inv_r;

  logic                 accept;
  logic                 start;
  logic                 wr_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] sum;
  logic [WORD_BITS-1:0] bits;

  assign accept = req_valid && req_ready;
  assign start  = accept && (req_type == REQ_FWD || req_type == REQ_INV);

  pbar_table #(
    .WORD_BITS(WORD_BITS),
    .IDX_W    (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_addr(IDX_W'(req_index)),
    .wr_data(WORD_BITS'(req_operand)),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (mask_r[WORD_BITS-1]) state_nxt = ST_HOLD;
      ST_HOLD: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = '0;
    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        wr_en     = req_valid && req_type == REQ_WRITE &&
                    (32'(req_index) < 32'(WORD_BITS));
      end
      ST_RUN:  rd_addr = cnt_r;
      ST_HOLD: res_valid = 1'b1;
      default: ;
    endcase
  end

  // forward: bit i of (x + a_i); inverse: set bit i when (x_partial + a_i)[i] != w[i]
  always_comb begin
    sum     = (inv_r ? acc_r : op_r) + rd_data;
    bits    = inv_r ? (sum ^ op_r) : sum;
    acc_nxt = acc_r | (bits & mask_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= WORD_BITS'(req_operand);
      inv_r  <= (req_type == REQ_INV);
      acc_r  <= '0;
      mask_r <= WORD_BITS'(1);
      cnt_r  <= IDX_W'(1);
    end else if (state_r == ST_RUN) begin
      acc_r  <= acc_nxt;
      mask_r <= mask_r << 1;
      cnt_r  <= cnt_r + IDX_W'(1);
    end
  end

  assign res_word = RES_W'(acc_r);

endmodule

[tb/pbar_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the per-bit addend recoder: addend table copy, recode predictor, result check.
package pbar_tb_pkg;
  import pbar_pkg::*;

  class recode_checker;
    logic [31:0] addends [32];
    logic [31:0] pending_words [$];
    int unsigned bad_count;
    int unsigned checked_count;
    int unsigned n_write;
    int unsigned n_fwd;
    int unsigned n_inv;
    int unsigned n_skip;

    function new();
      foreach (addends[i]) addends[i] = '0;
      bad_count     = 0;
      checked_count = 0;
      n_write       = 0;
      n_fwd         = 0;
      n_inv         = 0;
      n_skip        = 0;
    endfunction

    // bit i of the result is bit i of (x + addend i)
    function logic [31:0] fwd_recode(logic [31:0] x);
      logic [31:0] sum;
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
        sum  = x + addends[i];
        r[i] = sum[i];
      end
      return r;
    endfunction

    // lowest bit first; bit i of x is set where the partial sum disagrees
    function logic [31:0] inv_recode(logic [31:0] w);
      logic [31:0] sum;
      logic [31:0] x;
      x = '0;
      for (int i = 0; i < 32; i++) begin
        sum = x + addends[i];
        if (sum[i] != w[i]) x[i] = 1'b1;
      end
      return x;
    endfunction

    function void note_request(req_t kind, logic [4:0] idx, logic [31:0] opnd);
      case (kind)
        REQ_WRITE: begin
          addends[idx] = opnd;
          n_write++;
        end
        REQ_FWD: begin
          pending_words.push_back(fwd_recode(opnd));
          n_fwd++;
        end
        REQ_INV: begin
          pending_words.push_back(inv_recode(opnd));
          n_inv++;
        end
        default: n_skip++;
      endcase
    endfunction

    function void flag_error(string what);
      if (bad_count < 10) $display("result error: %s", what);
      bad_count++;
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_words.size() == 0) begin
        flag_error($sformatf("no result expected, got %08h", got));
      end else begin
        want = pending_words.pop_front();
        checked_count++;
        if (got !== want) flag_error($sformatf("expected %08h, got %08h", want, got));
      end
    endfunction

    function void check_drained();
      if (pending_words.size() != 0)
        flag_error($sformatf("%0d results never arrived", pending_words.size()));
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the per-bit addend recoder: stream drivers, monitor, watchdog and test sequence.
module tb_top;
  import pbar_pkg::*;
  import pbar_tb_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = WORD_BITS_DEF + 8;
  localparam int LONG_HOLD    = 400;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic [REQ_W-1:0]     in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [RES_W-1:0]     out_tdata;

  logic                 rx_holding   = 1'b0;
  int unsigned          tx_idle_pct  = 7;
  int unsigned          rx_stall_pct = 78;
  int unsigned          quiet_cycles = 0;
  event                 hold_kick;
  recode_checker        chk = new();

  per_bit_addend_recode u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rx_holding) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // long receiver stall, timed here so the sender keeps pushing meanwhile
  initial begin
    forever begin
      @(hold_kick);
      @(posedge clk);
      rx_holding <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      rx_holding <= 1'b0;
    end
  end

  // monitor plus watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      chk.note_request(req_t'(in_tuser), in_tdata[4:0], in_tdata[36:5]);
    if (rst_n && out_tvalid && out_tready)
      chk.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_request(req_t kind, logic [4:0] idx, logic [31:0] opnd);
    int unsigned gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, opnd, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      4: return 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int unsigned roll;
    logic [31:0] x;
    roll = $urandom_range(99);
    x    = pick_word();
    if (roll < 25) push_request(REQ_WRITE, 5'($urandom_range(31)), x);
    else if (roll < 55) push_request(REQ_FWD, 5'($urandom), x);
    else if (roll < 75) push_request(REQ_INV, 5'($urandom), x);
    // decode of an encoded word should round-trip
    else if (roll < 95) push_request(REQ_INV, 5'($urandom), chk.fwd_recode(x));
    else push_request(REQ_NONE, 5'($urandom), x);
  endtask

  task automatic wait_results();
    while (chk.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: both recodes are the identity
    push_request(REQ_FWD, 5'd0, 32'h0000_0000);
    push_request(REQ_FWD, 5'd31, 32'hFFFF_FFFF);
    push_request(REQ_INV, 5'd0, 32'h0000_0000);
    push_request(REQ_INV, 5'd31, 32'hFFFF_FFFF);
    push_request(REQ_WRITE, 5'd0, 32'hFFFF_FFFF);
    push_request(REQ_WRITE, 5'd31, 32'hFFFF_FFFF);
    push_request(REQ_WRITE, 5'd16, 32'h8000_0000);
    push_request(REQ_WRITE, 5'd1, 32'h0000_0001);
    // unused code must leave the table alone
    push_request(REQ_NONE, 5'd31, 32'hFFFF_FFFF);
    push_request(REQ_FWD, 5'd0, 32'h0000_0000);
    push_request(REQ_FWD, 5'd0, 32'hFFFF_FFFF);
    push_request(REQ_INV, 5'd0, 32'h0000_0000);
    push_request(REQ_INV, 5'd0, 32'hFFFF_FFFF);
    push_request(REQ_FWD, 5'd0, 32'hA5A5_A5A5);
    push_request(REQ_INV, 5'd0, 32'h5A5A_5A5A);
    push_request(REQ_WRITE, 5'd0, 32'h0000_0000);
    push_request(REQ_FWD, 5'd0, 32'hFFFF_FFFF);
    push_request(REQ_INV, 5'd0, 32'h1234_5678);

    repeat (310) random_request();

    tx_idle_pct = 78;
    rx_stall_pct <= 7;
    repeat (310) random_request();

    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    -> hold_kick;
    repeat (24) push_request($urandom_range(1) ? REQ_FWD : REQ_INV, 5'($urandom), pick_word());
    in_tvalid <= 1'b0;
    wait_results();

    repeat (290) random_request();
    in_tvalid <= 1'b0;

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    chk.check_drained();

    $display("Run covered %0d addend writes, %0d forward and %0d inverse recodes, %0d unused codes",
             chk.n_write, chk.n_fwd, chk.n_inv, chk.n_skip);
    $display("%0d results compared under sender gaps, receiver stalls and a long hold-off",
             chk.checked_count);
    if (chk.bad_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[per_bit_addend_recode.f]
rtl/pbar_pkg.sv
rtl/pbar_table.sv
rtl/pbar_seq.sv
rtl/per_bit_addend_recode.sv
tb/pbar_tb_pkg.sv
tb/tb_top.sv
